// ----- rtl/lsblend_pkg.sv -----
// shared widths, codes and types of the linear seam blend unit
package lsblend_pkg;

	localparam int unsigned COL_W        = 12;
	localparam int unsigned PIX_W        = 8;
	localparam int unsigned START_W      = 12;
	localparam int unsigned END_W        = 13;
	localparam int unsigned CHANNELS     = 3;
	localparam int unsigned MAX_WIDTH_DEF = 4096;
	localparam logic [END_W-1:0] END_RESET = 13'd4096;

	// blend numerator is at most 255 * (2^END_W - 1)
	localparam int unsigned NUM_W       = $clog2(255 * ((1 << END_W) - 1) + 1);
	// ceil(2^SHIFT / w) gives an exact floor quotient for every numerator
	localparam int unsigned RECIP_SHIFT = NUM_W + END_W;
	localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
	localparam int unsigned RECIP_LO_W  = RECIP_W / 2;
	localparam int unsigned RECIP_HI_W  = RECIP_W - RECIP_LO_W;

	localparam int unsigned IN_TDATA_W  = 64;
	localparam int unsigned OUT_TDATA_W = 24;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = END_W;

	localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_END   = 2'd1;

	typedef enum logic [1:0] {
		MODE_BASE,
		MODE_WARP,
		MODE_BLEND
	} mode_t;

	typedef logic [CHANNELS-1:0][PIX_W-1:0] pixel_t;

	// status of the reciprocal unit as seen by the top level
	typedef struct packed {
		logic                busy;
		logic [END_W-1:0]    width;
		logic [RECIP_W-1:0]  recip;
	} recip_stat_t;

endpackage

// ----- rtl/lsblend_recip.sv -----
// iterative reciprocal of the overlap width, one quotient bit per cycle
module lsblend_recip (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [lsblend_pkg::END_W-1:0]        divisor,
	output lsblend_pkg::recip_stat_t             stat
);

	localparam int unsigned RW    = lsblend_pkg::RECIP_W;
	localparam int unsigned EW    = lsblend_pkg::END_W;
	localparam int unsigned CNT_W = $clog2(RW);

	logic [RW-1:0]    dvd_q;
	logic [RW-1:0]    quo_q;
	logic [EW-1:0]    rem_q;
	logic [EW-1:0]    w_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic [EW:0]      trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[RW-1]};
	assign fits  = (trial >= {1'b0, w_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CNT_W'(RW - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// dividend is 2^SHIFT + w - 1 so the quotient rounds up
	always_ff @(posedge clk) begin
		if (start) begin
			w_q   <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			dvd_q <= {1'b1, (RW-1)'(0)} + RW'(divisor) - RW'(1);
		end else if (busy_q) begin
			rem_q <= fits ? EW'(trial - {1'b0, w_q}) : trial[EW-1:0];
			quo_q <= {quo_q[RW-2:0], fits};
			dvd_q <= {dvd_q[RW-2:0], 1'b0};
		end
	end

	assign stat.busy  = busy_q;
	assign stat.width = w_q;
	assign stat.recip = quo_q;

`ifndef SYNTHESIS
	a_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(cnt_q) == CNT_W'(RW - 1))
		else $error("reciprocal finished early");
`endif

endmodule

// ----- rtl/lsblend_lane.sv -----
// one colour channel: blend numerator and exact division by reciprocal
module lsblend_lane (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [lsblend_pkg::START_W-1:0]      k_s1,
	input  logic [lsblend_pkg::END_W-1:0]        width,
	input  logic [lsblend_pkg::RECIP_W-1:0]      recip,
	input  logic [lsblend_pkg::PIX_W-1:0]        base_s1,
	input  logic [lsblend_pkg::PIX_W-1:0]        warp_s1,
	output logic [lsblend_pkg::PIX_W-1:0]        base_s4,
	output logic [lsblend_pkg::PIX_W-1:0]        warp_s4,
	output logic [lsblend_pkg::PIX_W-1:0]        quot_s4
);

	localparam int unsigned NW  = lsblend_pkg::NUM_W;
	localparam int unsigned PW  = lsblend_pkg::PIX_W;
	localparam int unsigned LOW = lsblend_pkg::RECIP_LO_W;
	localparam int unsigned HIW = lsblend_pkg::RECIP_HI_W;
	localparam int unsigned SW  = NW + lsblend_pkg::RECIP_W;

	logic [lsblend_pkg::END_W-1:0] wk;
	logic [NW-1:0]                 num;
	logic [NW-1:0]                 num_s2;
	logic [NW+HIW-1:0]             pp_hi_s3;
	logic [NW+LOW-1:0]             pp_lo_s3;
	logic [SW-1:0]                 sum;
	logic [PW-1:0]                 base_s2, base_s3;
	logic [PW-1:0]                 warp_s2, warp_s3;

	assign wk  = width - lsblend_pkg::END_W'(k_s1);
	assign num = NW'(base_s1) * NW'(wk) + NW'(warp_s1) * NW'(k_s1);
	assign sum = (SW'(pp_hi_s3) << LOW) + SW'(pp_lo_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2   <= num;
			base_s2  <= base_s1;
			warp_s2  <= warp_s1;
			// reciprocal product split in two halves
			pp_hi_s3 <= (NW+HIW)'(num_s2) * (NW+HIW)'(recip[lsblend_pkg::RECIP_W-1:LOW]);
			pp_lo_s3 <= (NW+LOW)'(num_s2) * (NW+LOW)'(recip[LOW-1:0]);
			base_s3  <= base_s2;
			warp_s3  <= warp_s2;
			quot_s4  <= sum[lsblend_pkg::RECIP_SHIFT +: PW];
			base_s4  <= base_s3;
			warp_s4  <= warp_s3;
		end
	end

endmodule

// ----- rtl/lsblend_merge.sv -----
// picks the whole pixel by blend mode and holds the result in an output and skid register
module lsblend_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lsblend_pkg::mode_t    mode,
	input  lsblend_pkg::pixel_t   base,
	input  lsblend_pkg::pixel_t   warp,
	input  lsblend_pkg::pixel_t   quot,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lsblend_pkg::pixel_t   out_pix
);

	lsblend_pkg::pixel_t sel;
	lsblend_pkg::pixel_t out_q;
	lsblend_pkg::pixel_t skid_q;
	logic                out_v_q;
	logic                skid_v_q;
	logic                out_free;

	always_comb begin
		case (mode)
			lsblend_pkg::MODE_WARP:  sel = warp;
			lsblend_pkg::MODE_BLEND: sel = quot;
			default:                 sel = base;
		endcase
	end

	assign in_ready = !skid_v_q;
	assign out_free = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end else begin
				out_v_q  <= in_valid;
			end
		end else if (in_valid && in_ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_v_q ? skid_q : sel;
		end else if (in_valid && in_ready) begin
			skid_q <= sel;
		end
	end

	assign out_valid = out_v_q;
	assign out_pix   = out_q;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a pixel while output is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ready && in_valid && !skid_v_q |=> skid_v_q)
		else $error("pixel lost while output stalled");
`endif

endmodule

// ----- rtl/linear_seam_blend_unit.sv -----
// top level of the linear seam blend unit: decision stage, three channel lanes, merge
//
// stitches two images across a vertical seam, one rgb pixel per transfer
// s_* channel: column and the reference and warped pixel of one position
// m_* channel: the stitched pixel; left of the overlap the reference
//   passes, at or beyond its end the warped pixel, inside it a linear
//   feather blend, except where the warped pixel is black
// cfg_*: overlap_start (index 0) and overlap_end (index 1), written
//   while no pixel is in flight; each write starts a reciprocal of the
//   overlap width, and s_tready stays low meanwhile
// after reset the same reciprocal pass runs before the first transfer is taken
// a taken pixel passes stages s1 to s4 and then the merge output register to m_tdata
// throughput: one pixel per clock unless stalled, set by the three lanes each
//   with its numerator stage and a reciprocal multiply split over two stages
// when m_tready is low the output register holds and a skid register
//   takes one more pixel; s_tready then drops with the pipeline frozen
// division is exact: numerator times ceil(2^34 / width), keeping bits 41:34
module linear_seam_blend_unit #(
	parameter int unsigned MAX_WIDTH = lsblend_pkg::MAX_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// column[11:0], first_red[19:12], first_green[27:20], first_blue[35:28],
	// second_red[43:36], second_green[51:44], second_blue[59:52], zero[63:60]
	input  logic [lsblend_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// out_red[7:0], out_green[15:8], out_blue[23:16]
	output logic [lsblend_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                    cfg_we,
	input  logic [lsblend_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lsblend_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int unsigned CH = lsblend_pkg::CHANNELS;
	localparam int unsigned PW = lsblend_pkg::PIX_W;
	localparam int unsigned CW = lsblend_pkg::COL_W;
	localparam int unsigned SW = lsblend_pkg::START_W;
	localparam int unsigned EW = lsblend_pkg::END_W;

	// configuration registers
	logic [SW-1:0] start_q;
	logic [EW-1:0] end_q;
	logic          pend_q;

	// reciprocal unit
	lsblend_pkg::recip_stat_t rstat;
	logic                     recip_go;
	logic [EW-1:0]            end_eff;
	logic [EW-1:0]            width;

	// input unpacking and decision
	logic [CW-1:0]       col;
	lsblend_pkg::pixel_t in_base;
	lsblend_pkg::pixel_t in_warp;
	lsblend_pkg::mode_t  mode;
	logic                s_fire;
	logic                adv;

	// pipeline control and payload
	logic                v1_s1, v2_s2, v3_s3, v4_s4;
	lsblend_pkg::mode_t  mode_s1, mode_s2, mode_s3, mode_s4;
	logic [SW-1:0]       k_s1;
	lsblend_pkg::pixel_t base_s1, warp_s1;
	lsblend_pkg::pixel_t base_s4, warp_s4, quot_s4;

	lsblend_pkg::pixel_t out_pix;

	// overlap end saturates to the image limit
	assign end_eff = (32'(end_q) > MAX_WIDTH) ? EW'(MAX_WIDTH) : end_q;
	assign width   = end_eff - EW'(start_q);

	// configuration writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= lsblend_pkg::END_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lsblend_pkg::CFG_OVERLAP_START: start_q <= cfg_data[SW-1:0];
				lsblend_pkg::CFG_OVERLAP_END:   end_q   <= cfg_data[EW-1:0];
				default: ;
			endcase
		end
	end

	// a reciprocal pass is owed after reset and after every write
	assign recip_go = pend_q && !rstat.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b1;
		end else if (cfg_we) begin
			pend_q <= 1'b1;
		end else if (recip_go) begin
			pend_q <= 1'b0;
		end
	end

	lsblend_recip u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (recip_go),
		.divisor (width),
		.stat    (rstat)
	);

	// unpack the input transfer
	assign col = s_tdata[CW-1:0];
	always_comb begin
		for (int c = 0; c < CH; c++) begin
			in_base[c] = s_tdata[CW + c*PW +: PW];
			in_warp[c] = s_tdata[CW + (CH + c)*PW +: PW];
		end
	end

	// warped side wins at or beyond the end, reference left of start or on black
	always_comb begin
		if (EW'(col) >= end_eff) begin
			mode = lsblend_pkg::MODE_WARP;
		end else if ((col < start_q) || (in_warp == '0)) begin
			mode = lsblend_pkg::MODE_BASE;
		end else begin
			mode = lsblend_pkg::MODE_BLEND;
		end
	end

	// whole pipeline moves while the merge stage can take a pixel
	assign s_tready = adv && !pend_q && !rstat.busy;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else if (adv) begin
			v1_s1 <= s_fire;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode;
			k_s1    <= col - start_q;
			base_s1 <= in_base;
			warp_s1 <= in_warp;
			mode_s2 <= mode_s1;
			mode_s3 <= mode_s2;
			mode_s4 <= mode_s3;
		end
	end

	// one lane per colour channel
	for (genvar g = 0; g < CH; g++) begin : g_lane
		lsblend_lane u_lane (
			.clk     (clk),
			.en      (adv),
			.k_s1    (k_s1),
			.width   (rstat.width),
			.recip   (rstat.recip),
			.base_s1 (base_s1[g]),
			.warp_s1 (warp_s1[g]),
			.base_s4 (base_s4[g]),
			.warp_s4 (warp_s4[g]),
			.quot_s4 (quot_s4[g])
		);
	end

	lsblend_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v4_s4),
		.in_ready  (adv),
		.mode      (mode_s4),
		.base      (base_s4),
		.warp      (warp_s4),
		.quot      (quot_s4),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pix   (out_pix)
	);

	assign m_tdata = out_pix;

`ifndef SYNTHESIS
	a_no_take_while_recip: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |-> !rstat.busy && !pend_q)
		else $error("pixel taken while reciprocal not ready");

	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready)
		else $error("input open right after configuration write");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v4_s4 && !adv |=> v4_s4 && $stable(mode_s4))
		else $error("last stage changed while merge stalled");
`endif

endmodule

// ----- tb/linear_seam_blend_unit_tb.sv -----
// self-checking testbench of the linear seam blend unit: directed and random pixels
module linear_seam_blend_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lsblend_pkg::*;

	// register indexes that the block does not decode, written to show they are ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	// cycles to let pass after the last stitched pixel before touching the registers
	localparam int unsigned SETTLE_CYCLES = 12;
	// receiver hold-off long enough to fill the pipeline and the skid register
	localparam int unsigned HOLD_OFF_CYCLES = 300;

	// one pixel position, laid out as on s_tdata below the zero padding
	typedef struct packed {
		pixel_t            second;
		pixel_t            first;
		logic [COL_W-1:0]  column;
	} pix_item_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	// column[11:0], first_red[19:12], first_green[27:20], first_blue[35:28],
	// second_red[43:36], second_green[51:44], second_blue[59:52], zero[63:60]
	logic [IN_TDATA_W-1:0]   s_tdata = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	// out_red[7:0], out_green[15:8], out_blue[23:16]
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	// pixels waiting for the driver, and stitched pixels the block still owes
	pix_item_t   pending_pixels[$];
	pixel_t      owed_pixels[$];

	// local copy of the two overlap registers
	logic [START_W-1:0]  seam_start = '0;
	logic [END_W-1:0]    seam_end = END_RESET;

	int unsigned  send_idle_pct = 0;
	int unsigned  sink_stall_pct = 0;
	logic         receiver_hold = 1'b0;
	event         hold_off_go;

	int unsigned  pixels_queued = 0;
	int unsigned  pixels_checked = 0;
	int unsigned  reg_writes = 0;
	int unsigned  mode_hits[3] = '{0, 0, 0};
	int unsigned  fail_count = 0;

	string channel_name[CHANNELS] = '{"red", "green", "blue"};

	linear_seam_blend_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// expected stitched pixel for one position under the current overlap
	function automatic pixel_t stitch_pixel(input pix_item_t it, output mode_t mode);
		int unsigned        seam_limit;
		int unsigned        width;
		int unsigned        offset;
		longint unsigned    num;
		pixel_t             res;
		int                 c;
		// an end beyond the image width saturates
		seam_limit = (seam_end > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : seam_end;
		if (it.column >= seam_limit) begin
			mode = MODE_WARP;
			res = it.second;
		end else if (it.column < seam_start || it.second == '0) begin
			// left of the overlap, or a black warped pixel inside it
			mode = MODE_BASE;
			res = it.first;
		end else begin
			mode = MODE_BLEND;
			width = seam_limit - seam_start;
			offset = it.column - seam_start;
			for (c = 0; c < CHANNELS; c++) begin
				num = longint'(it.first[c]) * (width - offset) +
					longint'(it.second[c]) * offset;
				res[c] = 8'(num / width);
			end
		end
		return res;
	endfunction

	function automatic pixel_t rgb(input int unsigned r, input int unsigned g,
			input int unsigned b);
		return {8'(b), 8'(g), 8'(r)};
	endfunction

	// channel values lean on the extremes now and then
	function automatic logic [PIX_W-1:0] pick_channel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_t pick_pixel();
		return {pick_channel(), pick_channel(), pick_channel()};
	endfunction

	// columns mostly around the seam edges and inside the overlap
	function automatic logic [COL_W-1:0] pick_column();
		int   lo;
		int   hi;
		int   col;
		lo = seam_start;
		hi = (seam_end > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : seam_end;
		if (lo > hi) begin
			col = lo;
			lo = hi;
			hi = col;
		end
		case ($urandom_range(0, 3))
			0: col = $urandom_range(0, 4095);
			1: col = $urandom_range(lo, hi);
			2: col = seam_start + $urandom_range(0, 16) - 8;
			default: col = hi + $urandom_range(0, 16) - 8;
		endcase
		if (col < 0)
			col = 0;
		if (col > 4095)
			col = 4095;
		return COL_W'(col);
	endfunction

	task automatic queue_pixel(input int unsigned col, input pixel_t first,
			input pixel_t second);
		pix_item_t it;
		it.column = COL_W'(col);
		it.first = first;
		it.second = second;
		pending_pixels.insert(pending_pixels.size(), it);
		pixels_queued++;
	endtask

	task automatic queue_random_pixel();
		pixel_t second;
		second = pick_pixel();
		// black warped pixels now and then, inside the overlap too
		if ($urandom_range(0, 9) == 0)
			second = '0;
		queue_pixel(pick_column(), pick_pixel(), second);
	endtask

	// one register write; the local copy follows what the block keeps
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		case (idx)
			CFG_OVERLAP_START: seam_start = value[START_W-1:0];
			CFG_OVERLAP_END:   seam_end = value;
			default: ;
		endcase
	endtask

	// wait until every queued pixel has come back, then let the pipeline settle
	task automatic drain();
		while (pixels_checked < pixels_queued || pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_overlap(input int unsigned start, input int unsigned stop);
		write_reg(CFG_OVERLAP_START, CFG_DATA_W'(start));
		write_reg(CFG_OVERLAP_END, CFG_DATA_W'(stop));
	endtask

	// random overlap, with the corner settings weighted in
	task automatic pick_overlap();
		int unsigned  start;
		int unsigned  stop;
		case ($urandom_range(0, 11))
			0: begin
				start = 0;
				stop = 4096;
			end
			1: begin
				start = $urandom_range(0, 4095);
				stop = $urandom_range(4097, 8191);
			end
			2: begin
				// empty overlap: end at or below start
				stop = $urandom_range(0, 4095);
				start = $urandom_range(stop, 4095);
			end
			3: begin
				start = $urandom_range(0, 4095);
				stop = 0;
			end
			4: begin
				start = $urandom_range(0, 4095);
				stop = $urandom_range(0, 8191);
			end
			5: begin
				start = $urandom_range(0, 4095);
				stop = start + 1;
			end
			default: begin
				start = $urandom_range(0, 4000);
				stop = start + $urandom_range(1, 96);
			end
		endcase
		// bit 12 of the start write lies above the register and must be dropped
		if ($urandom_range(0, 1))
			start = start | 32'h1000;
		set_overlap(start, stop);
		if ($urandom_range(0, 3) == 0)
			write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
				CFG_DATA_W'($urandom_range(0, 8191)));
	endtask

	// driver: presents pending pixels and predicts each one as its transfer completes
	always @(posedge clk) begin
		mode_t    mode;
		pixel_t   want;
		if (s_tvalid && s_tready) begin
			want = stitch_pixel(pix_item_t'(s_tdata[$bits(pix_item_t)-1:0]), mode);
			owed_pixels.insert(owed_pixels.size(), want);
			mode_hits[mode]++;
		end
		if (!s_tvalid || s_tready) begin
			if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= {4'b0, pending_pixels.pop_front()};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: checks each stitched pixel against the oldest owed one
	always @(posedge clk) begin
		pixel_t   want;
		pixel_t   got;
		int       c;
		if (m_tvalid && m_tready) begin
			got = pixel_t'(m_tdata);
			if (owed_pixels.size() == 0) begin
				$display("%0t unexpected stitched pixel: expected none, got %h", $time, got);
				fail_count++;
			end else begin
				want = owed_pixels.pop_front();
				for (c = 0; c < CHANNELS; c++) begin
					if (got[c] !== want[c]) begin
						$display("%0t mismatch on %s: expected %0d, got %0d",
							$time, channel_name[c], want[c], got[c]);
						fail_count++;
					end
				end
				pixels_checked++;
			end
		end
		m_tready <= !receiver_hold && ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// receiver hold-off, counted here while the sender keeps offering
	initial begin
		int unsigned  held;
		@(hold_off_go);
		receiver_hold <= 1'b1;
		for (held = 0; held < HOLD_OFF_CYCLES; held++)
			@(posedge clk);
		receiver_hold <= 1'b0;
	end

	// stimulus
	initial begin
		int unsigned  phase;
		int unsigned  setting;
		int unsigned  n;
		int unsigned  send_mix[4];
		int unsigned  sink_mix[4];

		send_mix = '{0, 56, 0, 12};
		sink_mix = '{0, 0, 56, 12};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset overlap covers the whole row: k = 0 passes the reference exactly
		queue_pixel(0, rgb(255, 255, 255), rgb(0, 0, 1));
		queue_pixel(4095, rgb(0, 0, 0), rgb(255, 255, 255));
		queue_pixel(2048, rgb(200, 100, 50), rgb(0, 0, 0));
		queue_pixel(2048, rgb(255, 0, 255), rgb(0, 255, 0));
		drain();

		// a hundred-column seam: both edges, the middle and black warped pixels
		set_overlap(100, 200);
		queue_pixel(99, rgb(1, 2, 3), rgb(250, 251, 252));
		queue_pixel(100, rgb(9, 8, 7), rgb(200, 201, 202));
		queue_pixel(150, rgb(10, 20, 30), rgb(250, 240, 230));
		queue_pixel(199, rgb(255, 255, 255), rgb(255, 255, 255));
		queue_pixel(199, rgb(0, 0, 0), rgb(255, 255, 255));
		queue_pixel(200, rgb(40, 50, 60), rgb(70, 80, 90));
		queue_pixel(150, rgb(77, 88, 99), rgb(0, 0, 0));
		queue_pixel(150, rgb(77, 88, 99), rgb(0, 0, 5));
		drain();

		// empty overlap, end equal to start
		set_overlap(300, 300);
		queue_pixel(299, rgb(11, 22, 33), rgb(44, 55, 66));
		queue_pixel(300, rgb(11, 22, 33), rgb(44, 55, 66));
		queue_pixel(4095, rgb(11, 22, 33), rgb(0, 0, 0));
		drain();

		// empty overlap, end below start
		set_overlap(500, 200);
		queue_pixel(100, rgb(5, 6, 7), rgb(8, 9, 10));
		queue_pixel(300, rgb(5, 6, 7), rgb(8, 9, 10));
		queue_pixel(600, rgb(5, 6, 7), rgb(8, 9, 10));
		drain();

		// all-ones writes: start keeps 12 bits, end saturates to the image width
		set_overlap(32'h1FFF, 32'h1FFF);
		queue_pixel(4095, rgb(1, 2, 3), rgb(4, 5, 6));
		queue_pixel(4094, rgb(1, 2, 3), rgb(4, 5, 6));
		drain();

		// end of zero: the warped pixel everywhere; spare indexes change nothing
		set_overlap(0, 0);
		write_reg(CFG_SPARE_A, 13'd7);
		write_reg(CFG_SPARE_B, 13'h1FFF);
		queue_pixel(0, rgb(123, 45, 67), rgb(0, 0, 0));
		queue_pixel(4095, rgb(123, 45, 67), rgb(89, 10, 11));
		queue_pixel(17, rgb(0, 0, 0), rgb(255, 128, 1));
		drain();

		// random part: each idle mix runs through several overlap settings
		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct = send_mix[phase];
			sink_stall_pct = sink_mix[phase];
			for (setting = 0; setting < 4; setting++) begin
				pick_overlap();
				for (n = 0; n < 100; n++)
					queue_random_pixel();
				drain();
			end
		end

		// back pressure: receiver holds off while the sender keeps offering
		send_idle_pct = 0;
		sink_stall_pct = 0;
		set_overlap(1000, 1064);
		-> hold_off_go;
		for (n = 0; n < 120; n++)
			queue_random_pixel();
		drain();

		// widest overlap last
		set_overlap(0, 4096);
		for (n = 0; n < 60; n++)
			queue_random_pixel();
		drain();

		if (owed_pixels.size() != 0) begin
			$display("%0t %0d stitched pixels never arrived", $time, owed_pixels.size());
			fail_count++;
		end
		$display("checked %0d pixels across %0d register writes", pixels_checked, reg_writes);
		$display("outcomes: %0d reference, %0d warped, %0d blended; idle mixes and a hold-off",
			mode_hits[MODE_BASE], mode_hits[MODE_WARP], mode_hits[MODE_BLEND]);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#(2_000_000);
		$display("%0t run timed out", $time);
		$display("status: fail");
		$finish;
	end

endmodule
